>>> hdl/ppbd_pkg.sv
// ----------------------------------------------------------------------------
// ppbd_pkg
// Types and codes shared by the point to polygon boundary distance block.
// ----------------------------------------------------------------------------
package ppbd_pkg;

  // Configuration register indexes
  localparam logic [0:0] RegQueryX = 1'b0;
  localparam logic [0:0] RegQueryY = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [10:0] {
    StIdle  = 11'b000_0000_0001,
    StSetup = 11'b000_0000_0010,
    StMulA  = 11'b000_0000_0100,
    StMulB  = 11'b000_0000_1000,
    StDecide= 11'b000_0001_0000,
    StDivX  = 11'b000_0010_0000,
    StDivY  = 11'b000_0100_0000,
    StFoot  = 11'b000_1000_0000,
    StNext  = 11'b001_0000_0000,
    StSqrt  = 11'b010_0000_0000,
    StOut   = 11'b100_0000_0000
  } state_e;

endpackage

>>> hdl/point_polygon_boundary_distance.sv
// ----------------------------------------------------------------------------
// point_polygon_boundary_distance
// Running minimum distance from a query point to the boundary of a polygon.
// ----------------------------------------------------------------------------
// A vertex that closes no segment stalls the input while it is set up; one that
// closes a segment also takes the shared multiplier, and when the foot lies on
// the segment, two passes of the shared divider, for x and then for y. The last
// vertex adds its closing segment and a square root. One vertex is in work at a
// time; the output register holds a result while the next polygon runs. Reset
// clears the control state; the datapath registers have no reset.
module point_polygon_boundary_distance #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_index_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  logic                          is_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [COORD_WIDTH:0]          distance_o
);
  import ppbd_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;           // coordinate difference
  localparam int PW = 2 * W + 2;       // squares, dot, length
  localparam int CW = $clog2(DW);

  state_e state_q, state_d;
  logic signed [W-1:0] qx_q, qy_q, fx_q, fy_q, px_q, py_q, vx_q, vy_q;
  logic have_q, last_q, closing_q;
  logic [PW-1:0] best_q;
  logic signed [DW-1:0] dx_q, dy_q, wx_q, wy_q;
  logic [PW-1:0] len_q;
  logic signed [PW:0] dot_q;
  logic [DW-1:0] mag_q, quo_q, ox_q;
  logic [PW:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic [PW-1:0] ea_q, eb_q;
  logic [PW-1:0] sv_q;
  logic [W:0] dist_q, out_dist_q;
  logic out_valid_q;

  // shared signed multiplier
  logic signed [DW-1:0] ma, mb;
  logic signed [PW:0] mp;
  assign ma = (state_q == StDecide) ? dy_q : dx_q;
  assign mb = (state_q == StDecide) ? wy_q : wx_q;
  assign mp = (PW+1)'(ma * mb);

  // segment endpoints
  logic signed [W-1:0] s1x, s1y, s2x, s2y;
  assign s1x = closing_q ? vx_q : px_q;
  assign s1y = closing_q ? vy_q : py_q;
  assign s2x = closing_q ? fx_q : vx_q;
  assign s2y = closing_q ? fy_q : vy_q;

  function automatic logic [PW-1:0] sqd(logic signed [W-1:0] ax, logic signed [W-1:0] ay,
                                          logic signed [W-1:0] bx, logic signed [W-1:0] by);
    logic signed [DW-1:0] ex, ey;
    ex = DW'(ax) - DW'(bx);
    ey = DW'(ay) - DW'(by);
    return PW'(ex * ex) + PW'(ey * ey);
  endfunction

  // multiply-divide step: take one bit of |d|, add dot, reduce by len or 2*len
  logic [PW+1:0] acc, sub1, sub2;
  logic [PW:0] rem_nxt;
  logic [1:0] digit;
  logic [DW-1:0] quo_nxt, quo_fin;
  logic rnd_up;
  assign acc  = {rem_q, 1'b0} + (mag_q[DW-1] ? {1'b0, dot_q[PW:0]} : '0);
  assign sub1 = acc - {2'b00, len_q};
  assign sub2 = acc - {1'b0, len_q, 1'b0};

  always_comb begin
    if (!sub2[PW+1]) begin
      digit   = 2'd2;
      rem_nxt = sub2[PW:0];
    end else if (!sub1[PW+1]) begin
      digit   = 2'd1;
      rem_nxt = sub1[PW:0];
    end else begin
      digit   = 2'd0;
      rem_nxt = acc[PW:0];
    end
  end

  assign quo_nxt = {quo_q[DW-2:0], 1'b0} + {{(DW-2){1'b0}}, digit};
  // round half away from the segment start
  assign rnd_up  = ({rem_nxt, 1'b0} >= {2'b00, len_q});
  assign quo_fin = quo_nxt + {{(DW-1){1'b0}}, rnd_up};

  // isqrt digit step
  logic [PW+1:0] sq_rem2, sq_try;
  logic [PW:0] sq_rem_nxt;
  logic [W:0] root_nxt;
  assign sq_rem2    = {rem_q[PW-1:0], sv_q[PW-1:PW-2]};
  assign sq_try     = sq_rem2 - {{(PW-W-1){1'b0}}, dist_q, 2'b01};
  assign sq_rem_nxt = sq_try[PW+1] ? sq_rem2[PW:0] : sq_try[PW:0];
  assign root_nxt   = sq_try[PW+1] ? {dist_q[W-1:0], 1'b0} : {dist_q[W-1:0], 1'b1};

  logic [DW-1:0] magx, magy;
  assign magx = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
  assign magy = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);

  logic signed [W+1:0] footx, footy;
  assign footx = dx_q[DW-1] ? (W+2)'(s1x) - (W+2)'(ox_q) : (W+2)'(s1x) + (W+2)'(ox_q);
  assign footy = dy_q[DW-1] ? (W+2)'(s1y) - (W+2)'(quo_q)
                            : (W+2)'(s1y) + (W+2)'(quo_q);
  logic signed [W+2:0] fex, fey;
  assign fex = (W+3)'(qx_q) - (W+3)'(footx);
  assign fey = (W+3)'(qy_q) - (W+3)'(footy);
  logic [PW-1:0] foot_sq;
  assign foot_sq = PW'(fex * fex) + PW'(fey * fey);

  logic signed [PW:0] dotl;
  assign dotl = dot_q + mp;

  logic [PW-1:0] cand;
  logic cand_en;

  always_comb begin
    state_d = state_q;
    cand    = ea_q < eb_q ? ea_q : eb_q;
    cand_en = 1'b0;
    unique case (state_q)
      StIdle:   if (in_valid_i && !in_stall_o) state_d = StSetup;
      StSetup:  state_d = have_q ? StMulA : StNext;
      StMulA:   state_d = StMulB;
      StMulB:   state_d = StDecide;
      StDecide: begin
        if (len_q == '0 || dotl[PW] || $unsigned(dotl) > {1'b0, len_q}) begin
          cand_en = 1'b1;
          state_d = StNext;
        end else begin
          state_d = StDivX;
        end
      end
      StDivX:   if (cnt_q == '0) state_d = StDivY;
      StDivY:   if (cnt_q == '0) state_d = StFoot;
      StFoot:   begin cand = foot_sq; cand_en = 1'b1; state_d = StNext; end
      StNext:   state_d = (last_q && !closing_q) ? StMulA : (last_q ? StSqrt : StIdle);
      StSqrt:   if (cnt_q == '0) state_d = StOut;
      StOut:    if (!out_valid_q) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      qx_q <= '0; qy_q <= '0; fx_q <= '0; fy_q <= '0; px_q <= '0; py_q <= '0;
      vx_q <= '0; vy_q <= '0;
      have_q <= 1'b0; last_q <= 1'b0; closing_q <= 1'b0;
      best_q <= '1; out_valid_q <= 1'b0; cnt_q <= '0; out_dist_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegQueryX: qx_q <= cfg_data_i;
          RegQueryY: qy_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cand_en && cand < best_q) best_q <= cand;
      unique case (state_q)
        StIdle: if (in_valid_i && !in_stall_o) begin
          vx_q <= vertex_x_i; vy_q <= vertex_y_i; last_q <= is_last_i;
          closing_q <= 1'b0;
          if (!have_q) begin fx_q <= vertex_x_i; fy_q <= vertex_y_i; end
        end
        StSetup: have_q <= 1'b1;
        StDecide: cnt_q <= CW'(DW - 1);
        StDivX: begin
          if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
          else cnt_q <= CW'(DW - 1);
        end
        StDivY: if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
        StNext: begin
          if (last_q && !closing_q) closing_q <= 1'b1;
          else begin px_q <= vx_q; py_q <= vy_q; end
          if (last_q && closing_q) cnt_q <= CW'(W);
        end
        StSqrt: if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
        StOut: if (!out_valid_q) begin
          out_valid_q <= 1'b1; out_dist_q <= dist_q;
          have_q <= 1'b0; best_q <= '1; closing_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StMulA: begin
        dx_q <= DW'(s2x) - DW'(s1x); dy_q <= DW'(s2y) - DW'(s1y);
        wx_q <= DW'(qx_q) - DW'(s1x); wy_q <= DW'(qy_q) - DW'(s1y);
        ea_q <= sqd(qx_q, qy_q, s1x, s1y); eb_q <= sqd(qx_q, qy_q, s2x, s2y);
        len_q <= sqd(s2x, s2y, s1x, s1y);
        dot_q <= '0;
      end
      StMulB: dot_q <= mp;
      StDecide: begin
        dot_q <= dotl;
        mag_q <= magx;
        rem_q <= '0; quo_q <= '0;
      end
      StDivX: begin
        if (cnt_q == '0) begin
          ox_q <= quo_fin;
          mag_q <= magy;
          rem_q <= '0; quo_q <= '0;
        end else begin
          mag_q <= {mag_q[DW-2:0], 1'b0};
          rem_q <= rem_nxt; quo_q <= quo_nxt;
        end
      end
      StDivY: begin
        if (cnt_q == '0) quo_q <= quo_fin;
        else begin
          mag_q <= {mag_q[DW-2:0], 1'b0};
          rem_q <= rem_nxt; quo_q <= quo_nxt;
        end
      end
      StNext: begin sv_q <= best_q; rem_q <= '0; dist_q <= '0; end
      StSqrt: begin
        sv_q <= {sv_q[PW-3:0], 2'b00};
        rem_q <= sq_rem_nxt;
        // round: add one when remainder exceeds root, hold at all ones
        if (cnt_q == '0 && sq_rem_nxt > {{(PW-W){1'b0}}, root_nxt} && root_nxt != '1)
          dist_q <= root_nxt + 1'b1;
        else
          dist_q <= root_nxt;
      end
      default: ;
    endcase
  end

  assign distance_o = out_dist_q;

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> in_stall_o) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_o))
    else $error("result dropped");
  a_best_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> best_q == '1) else $error("minimum not cleared");
endmodule

>>> tb/point_polygon_boundary_distance_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_polygon_boundary_distance_test
// Feeds polygons vertex by vertex and checks each boundary distance against a
// bit-exact predictor or a fixed value, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module point_polygon_boundary_distance_test;
  import ppbd_pkg::*;

  localparam int W = 24;
  localparam longint CMAX = 64'sd8388607;
  localparam longint CMIN = -64'sd8388608;
  localparam longint BEST_INIT = (64'sd1 <<< 50) - 1;
  localparam longint DIST_MAX = (64'sd1 <<< 25) - 1;
  localparam int SETTLE = 400;
  localparam int ITEM_GOAL = 1550;
  localparam int PHASES = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = RegQueryX;
  logic [W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [W-1:0] vertex_x_i = '0;
  logic signed [W-1:0] vertex_y_i = '0;
  logic is_last_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [W:0] distance_o;

  point_polygon_boundary_distance #(.COORD_WIDTH(W)) dut (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // predictor state
  longint qx, qy, first_x, first_y, prev_x, prev_y, best_sq;
  bit have_vertex;
  logic [W:0] dist_q[$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int polygons = 0;

  task automatic report(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic longint sq_gap(longint ax, longint ay, longint bx, longint by);
    return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
  endfunction

  // round(mag * dot / len), halves away from the start
  function automatic longint foot_offset(longint mag, longint dot, longint len);
    logic [127:0] prod, q, r;
    prod = 128'(mag) * 128'(dot);
    q = prod / 128'(len);
    r = prod % 128'(len);
    if (2 * r >= 128'(len)) q++;
    return longint'(q);
  endfunction

  function automatic longint rounded_root(longint v);
    longint s;
    s = longint'($floor($sqrt(real'(v))));
    while (s * s > v) s--;
    while ((s + 1) * (s + 1) <= v) s++;
    if (v - s * s > s) s++;
    return s;
  endfunction

  task automatic fold_segment(input longint x1, y1, x2, y2);
    longint dx, dy, wx, wy, len, dot, fx, fy, cand, a, b;
    dx = x2 - x1;
    dy = y2 - y1;
    wx = qx - x1;
    wy = qy - y1;
    len = dx * dx + dy * dy;
    dot = dx * wx + dy * wy;
    if (len != 0 && dot >= 0 && dot <= len) begin
      fx = foot_offset(dx < 0 ? -dx : dx, dot, len);
      fy = foot_offset(dy < 0 ? -dy : dy, dot, len);
      fx = x1 + (dx < 0 ? -fx : fx);
      fy = y1 + (dy < 0 ? -fy : fy);
      cand = sq_gap(qx, qy, fx, fy);
    end else begin
      a = sq_gap(qx, qy, x1, y1);
      b = sq_gap(qx, qy, x2, y2);
      cand = a < b ? a : b;
    end
    if (cand < best_sq) best_sq = cand;
  endtask

  task automatic predict_vertex(input longint vx, vy, input bit last,
                                output bit got, output logic [W:0] exp_dist);
    longint d;
    got = 1'b0;
    exp_dist = '0;
    if (!have_vertex) begin
      first_x = vx;
      first_y = vy;
      have_vertex = 1'b1;
    end else begin
      fold_segment(prev_x, prev_y, vx, vy);
    end
    prev_x = vx;
    prev_y = vy;
    if (last) begin
      fold_segment(vx, vy, first_x, first_y);
      d = rounded_root(best_sq);
      if (d > DIST_MAX) d = DIST_MAX;
      got = 1'b1;
      exp_dist = d[W:0];
      have_vertex = 1'b0;
      best_sq = BEST_INIT;
    end
  endtask

  // check each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (dist_q.size() == 0)
        report($sformatf("unexpected distance %0d", distance_o));
      else begin
        if (distance_o !== dist_q[0])
          report($sformatf("distance %0d, expected %0d", distance_o, dist_q[0]));
        void'(dist_q.pop_front());
      end
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  int stall_pct = 30;
  bit hold_req = 1'b0;
  int hold_left = 0;
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 1500;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else
      out_stall_i = ($urandom_range(0, 99) < stall_pct);
  end

  int burst_left = 0;
  int gap_max = 5;

  // offer one vertex transaction; called and returns at a falling edge
  task automatic send_vertex(input longint vx, vy, input bit last,
                             input bit known, input logic [W:0] known_dist);
    bit got;
    logic [W:0] exp_dist;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    vertex_x_i = vx[W-1:0];
    vertex_y_i = vy[W-1:0];
    is_last_i = last;
    in_valid_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    predict_vertex(vx, vy, last, got, exp_dist);
    if (got) begin
      dist_q.push_back(known ? known_dist : exp_dist);
      polygons++;
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (dist_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input longint val);
    cfg_index_i = idx;
    cfg_data_i = val[W-1:0];
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic longint near(longint c);
    longint v;
    v = c + longint'($urandom_range(0, 8191)) - 4096;
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v;
  endfunction

  function automatic longint any_coord();
    return longint'(signed'(W'($urandom())));
  endfunction

  typedef struct {
    longint x;
    longint y;
    bit last;
    bit known;
    logic [W:0] exp_dist;
  } vertex_row_t;

  // query stays at the origin, its reset value
  vertex_row_t directed[] = '{
    '{768, 1024, 1, 1, 25'd1280},
    '{0, 0, 1, 1, 25'd0},
    '{-256, -256, 0, 0, 0},
    '{256, -256, 0, 0, 0},
    '{256, 256, 0, 0, 0},
    '{-256, 256, 1, 1, 25'd256},
    '{512, 0, 0, 0, 0},
    '{512, 0, 0, 0, 0},
    '{512, 0, 1, 1, 25'd512},
    '{1024, 0, 0, 0, 0},
    '{2048, 0, 1, 1, 25'd1024},
    '{CMIN, CMIN, 0, 0, 0},
    '{CMAX, CMAX, 0, 0, 0},
    '{CMAX, CMIN, 1, 0, 0},
    '{CMIN, CMAX, 0, 0, 0},
    '{CMAX, CMIN, 1, 0, 0},
    '{0, 256, 0, 0, 0},
    '{256, 0, 1, 0, 0},
    '{CMAX, 0, 1, 0, 0},
    '{0, CMIN, 1, 0, 0}
  };

  initial begin
    longint px, py;
    int n, mode, target;
    qx = 0;
    qy = 0;
    have_vertex = 1'b0;
    best_sq = BEST_INIT;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i])
      send_vertex(directed[i].x, directed[i].y, directed[i].last,
                  directed[i].known, directed[i].exp_dist);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        repeat (SETTLE) @(negedge clk_i);
        case (ph)
          1: begin px = CMAX; py = CMAX; end
          2: begin px = CMIN; py = CMIN; end
          3: begin px = CMIN; py = CMAX; end
          default: begin px = any_coord(); py = any_coord(); end
        endcase
        write_reg(RegQueryX, px);
        write_reg(RegQueryY, py);
        qx = px;
        qy = py;
      end
      stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 70);
      gap_max = (ph % 4 == 1) ? 0 : $urandom_range(1, 8);
      target = ITEM_GOAL * (ph + 1) / PHASES;
      while (items_sent < target) begin
        if ($urandom_range(0, 29) == 0) hold_req = 1'b1;
        if ($urandom_range(0, 24) == 0) drain();
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
        mode = $urandom_range(0, 2);
        for (int k = 0; k < n; k++) begin
          if (mode == 0 || (mode == 2 && $urandom_range(0, 1)))
            send_vertex(any_coord(), any_coord(), k == n - 1, 0, 0);
          else
            send_vertex(near(qx), near(qy), k == n - 1, 0, 0);
        end
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk_i);
    $display("Covered %0d vertices in %0d polygons over %0d query settings,",
             items_sent, polygons, PHASES);
    $display("with %0d distances checked and %0d mismatches.", results_seen, errors);
    if (errors == 0 && dist_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
